// ===== hw/rtl/pnz_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pnz_pkg;

  // fixed field widths
  localparam int COORD_W    = 24;
  localparam int PERM_W     = 8;
  localparam int PERM_AW    = 8;
  localparam int PERM_DEPTH = 256;
  localparam int OUT_W      = 16;
  localparam int AMP_W      = 17;
  localparam int PERS_W     = 16;
  localparam int OCT_CNT_W  = 4;
  localparam int OCT_IDX_W  = 4;
  localparam int STEP_W     = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [AMP_W-1:0]  AMP_ONE = 17'h10000;
  localparam logic [OUT_W-1:0]  OUT_MAX = 16'hFFFF;
  localparam logic [PERS_W-1:0] PERS_RESET = 16'h8000;
  localparam logic [OCT_CNT_W-1:0] OCT_CNT_RESET = 4'd1;

  // transaction modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = 1'b1;

  // gradient selection codes
  localparam logic [3:0] GRAD_U_FROM_Y = 4'd8;
  localparam logic [3:0] GRAD_V_FROM_Y = 4'd4;
  localparam logic [3:0] GRAD_V_X_A    = 4'd12;
  localparam logic [3:0] GRAD_V_X_B    = 4'd14;

  typedef struct packed {
    logic               mode;
    logic [PERM_W-1:0]  perm_index;
    logic [PERM_W-1:0]  perm_value;
    logic [COORD_W-1:0] coord_x;
    logic [COORD_W-1:0] coord_y;
    logic [COORD_W-1:0] coord_z;
  } pnz_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] noise_value;
  } pnz_out_t;

  // one octave travelling down the pipeline
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [OCT_IDX_W-1:0] octave;
    logic [AMP_W-1:0]     amp;
  } pnz_issue_t;

  typedef struct packed {
    logic               we;
    logic [PERM_AW-1:0] addr;
    logic [PERM_W-1:0]  data;
  } pnz_perm_wr_t;

  typedef struct packed {
    logic req_ready;
    logic res_valid;
  } pnz_div_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pnz_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pnz_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/perlin_noise_3d_octaves.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 3D improved Perlin noise summed over octaves. A mode 0 transaction stores one byte of
// the 256-entry permutation table; every entry an evaluation may touch must have been
// written first. A mode 1 transaction takes Q8.FRAC_BITS coordinates and issues its n
// octaves (n = octave_count, at least 1, at most MAX_OCTAVES) into a ten-stage pipeline,
// one octave per cycle: hash lookups in three levels of replicated dual-read permutation
// memories, fade curves, gradients and three interpolation stages, then the amplitude
// weighting and sum. The next transaction is accepted once the sum has been handed to
// the restoring divider; that hand-off waits while the divider still works on the
// previous sum, so short evaluations in a row run at the divider's pace. A result skips
// the division steps when the sum is not positive or saturates. The result waits in an
// output register while the next transaction is taken.
module perlin_noise_3d_octaves #(
  parameter int FRAC_BITS   = 16,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pnz_stream_if.sink                     in_s,
  pnz_stream_if.source                   out_s,
  input  logic                           cfg_we,
  input  logic [pnz_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [pnz_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int F     = FRAC_BITS;
  localparam int GW    = F + 3;
  localparam int AMP_W = pnz_pkg::AMP_W;
  localparam int NW    = $clog2(MAX_OCTAVES + 1);
  localparam int ASW   = AMP_W + NW;
  localparam int PRW   = GW + AMP_W + 1;
  localparam int TW    = PRW + NW + 1;
  localparam int DEN_W = ASW + F + 1;

  // configuration registers
  logic [pnz_pkg::OCT_CNT_W-1:0] oct_cnt_r;
  logic [pnz_pkg::PERS_W-1:0]    pers_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oct_cnt_r <= pnz_pkg::OCT_CNT_RESET;
      pers_r    <= pnz_pkg::PERS_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        pnz_pkg::REG_OCTAVE_COUNT: oct_cnt_r <= cfg_wdata[pnz_pkg::OCT_CNT_W-1:0];
        pnz_pkg::REG_PERSISTENCE:  pers_r    <= cfg_wdata[pnz_pkg::PERS_W-1:0];
        default: ;
      endcase
    end
  end

  // input transaction decode
  logic                  in_acc, eval_acc;
  pnz_pkg::pnz_perm_wr_t perm_wr;
  logic [NW-1:0]         n_eval;

  assign in_acc        = in_s.valid && in_s.ready;
  assign eval_acc      = in_acc && (in_s.data.mode == pnz_pkg::MODE_EVAL);
  assign perm_wr.we    = in_acc && (in_s.data.mode == pnz_pkg::MODE_WRITE);
  assign perm_wr.addr  = in_s.data.perm_index;
  assign perm_wr.data  = in_s.data.perm_value;

  // octave count clamped to one..MAX_OCTAVES
  always_comb begin
    if (oct_cnt_r == '0) begin
      n_eval = NW'(1);
    end else if (32'(oct_cnt_r) > MAX_OCTAVES) begin
      n_eval = NW'(MAX_OCTAVES);
    end else begin
      n_eval = NW'(oct_cnt_r);
    end
  end

  // octave sequencer
  logic                          busy_r, issuing_r, fin_r;
  logic [pnz_pkg::OCT_IDX_W-1:0] oct_r;
  logic [NW-1:0]                 n_r;
  logic [AMP_W-1:0]              amp_r;
  logic [ASW-1:0]                amp_sum_r;
  logic [pnz_pkg::COORD_W-1:0]   cx_r, cy_r, cz_r;
  logic [AMP_W+pnz_pkg::PERS_W-1:0] amp_prod;
  logic                          iss_last;
  pnz_pkg::pnz_issue_t           iss;

  assign iss_last     = (5'(oct_r) + 5'd1) == 5'(n_r);
  assign iss.valid    = issuing_r;
  assign iss.last     = iss_last;
  assign iss.octave   = oct_r;
  assign iss.amp      = amp_r;
  assign amp_prod     = amp_r * pers_r;

  // octave pipeline
  pnz_pkg::pnz_issue_t   oc_ctl;
  logic signed [GW-1:0]  oc_val;

  pnz_octave #(.FRAC_BITS(F)) u_octave (
    .clk(clk), .rst_n(rst_n), .wr(perm_wr), .iss(iss),
    .cx(cx_r), .cy(cy_r), .cz(cz_r), .ctl_o(oc_ctl), .val_o(oc_val)
  );

  // amplitude weighting and sum
  logic signed [PRW-1:0] prod_r;
  logic                  pv_r, plast_r;
  logic signed [TW-1:0]  acc_r;

  // normalization
  pnz_pkg::pnz_div_stat_t   div_stat;
  logic                     div_req, div_take;
  logic [pnz_pkg::OUT_W-1:0] div_q;

  assign div_req = fin_r && div_stat.req_ready;

  pnz_divider #(.NUM_W(TW), .DEN_W(DEN_W)) u_divider (
    .clk(clk), .rst_n(rst_n), .req_valid(div_req), .num(acc_r),
    .den(DEN_W'(amp_sum_r) << (F + 1)), .res_ready(div_take),
    .stat(div_stat), .quot(div_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      issuing_r <= 1'b0;
      fin_r     <= 1'b0;
      pv_r      <= 1'b0;
      plast_r   <= 1'b0;
    end else begin
      pv_r    <= oc_ctl.valid;
      plast_r <= oc_ctl.last;
      if (eval_acc) begin
        busy_r    <= 1'b1;
        issuing_r <= 1'b1;
      end else if (issuing_r && iss_last) begin
        issuing_r <= 1'b0;
      end
      if (pv_r && plast_r) begin
        fin_r <= 1'b1;
      end else if (div_req) begin
        fin_r  <= 1'b0;
        busy_r <= 1'b0;
      end
    end
  end

  // sequencer and accumulator datapath
  always_ff @(posedge clk) begin
    if (eval_acc) begin
      cx_r      <= in_s.data.coord_x;
      cy_r      <= in_s.data.coord_y;
      cz_r      <= in_s.data.coord_z;
      n_r       <= n_eval;
      oct_r     <= '0;
      amp_r     <= pnz_pkg::AMP_ONE;
      amp_sum_r <= '0;
    end else if (issuing_r) begin
      oct_r     <= oct_r + 1'b1;
      amp_r     <= amp_prod[AMP_W+pnz_pkg::PERS_W-1:pnz_pkg::PERS_W];
      amp_sum_r <= amp_sum_r + ASW'(amp_r);
    end
    prod_r <= oc_val * $signed({1'b0, oc_ctl.amp});
    if (eval_acc) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + TW'(prod_r);
    end
  end

  // output register
  logic                      out_valid_r;
  logic [pnz_pkg::OUT_W-1:0] out_data_r;

  assign div_take = !out_valid_r || out_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_stat.res_valid && div_take) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_stat.res_valid && div_take) begin
      out_data_r <= div_q;
    end
  end

  assign in_s.ready             = !busy_r;
  assign out_s.valid            = out_valid_r;
  assign out_s.data.noise_value = out_data_r;

  // no octave in flight while a new transaction can enter
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_s.ready |-> (!issuing_r && !fin_r && !pv_r))
    else $error("transaction accepted with octaves in flight");

  // issued octave stays below the clamped count
  a_oct_range: assert property (@(posedge clk) disable iff (!rst_n)
    issuing_r |-> (5'(oct_r) < 5'(n_r)))
    else $error("octave index beyond count");

  // amplitude never grows above one
  a_amp_max: assert property (@(posedge clk) disable iff (!rst_n)
    issuing_r |-> (amp_r <= pnz_pkg::AMP_ONE))
    else $error("amplitude above one");

  // hand-off to the divider frees the sequencer
  a_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    div_req |=> (!fin_r && !busy_r))
    else $error("sum not released after divider request");

endmodule

`default_nettype wire

// ===== hw/rtl/pnz_perm_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pnz_perm_mem (
  input  logic                        clk,
  input  pnz_pkg::pnz_perm_wr_t       wr,
  input  logic [pnz_pkg::PERM_AW-1:0] ra0,
  input  logic [pnz_pkg::PERM_AW-1:0] ra1,
  output logic [pnz_pkg::PERM_W-1:0]  rd0,
  output logic [pnz_pkg::PERM_W-1:0]  rd1
);

  logic [pnz_pkg::PERM_W-1:0] mem_r [pnz_pkg::PERM_DEPTH];
  logic [pnz_pkg::PERM_W-1:0] rd0_r;
  logic [pnz_pkg::PERM_W-1:0] rd1_r;

  // one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd0_r <= mem_r[ra0];
    rd1_r <= mem_r[ra1];
  end

  assign rd0 = rd0_r;
  assign rd1 = rd1_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pnz_fade.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pnz_fade #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FRAC_BITS:0]   f
);

  localparam int F  = FRAC_BITS;
  localparam int QW = F + 4;
  localparam logic [QW-1:0] TEN_ONE = QW'(10) << F;
  localparam logic [F:0]    ONE     = (F + 1)'(1) << F;

  logic [F-1:0]    t2_r;
  logic [F-1:0]    t1_r;
  logic [F-1:0]    t3_r;
  logic [QW-1:0]   q_r;
  logic [F:0]      f_r;
  logic [2*F-1:0]  tt;
  logic [2*F-1:0]  ttt;
  logic [QW:0]     q_nxt;
  logic [2*F+3:0]  fq;
  logic [QW-1:0]   f_nxt;

  // t squared
  assign tt = t * t;

  // t cubed and 6t^2 - 15t + 10
  assign ttt   = t2_r * t1_r;
  assign q_nxt = (QW + 1)'(6) * (QW + 1)'(t2_r) + (QW + 1)'(TEN_ONE)
               - (QW + 1)'(15) * (QW + 1)'(t1_r);

  // product, limited to one
  assign fq    = t3_r * q_r;
  assign f_nxt = fq[2*F+3:F];

  always_ff @(posedge clk) begin
    t2_r <= tt[2*F-1:F];
    t1_r <= t;
    t3_r <= ttt[2*F-1:F];
    q_r  <= q_nxt[QW-1:0];
    f_r  <= (f_nxt > QW'(ONE)) ? ONE : f_nxt[F:0];
  end

  assign f = f_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pnz_octave.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pnz_octave #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pnz_pkg::pnz_perm_wr_t       wr,
  input  pnz_pkg::pnz_issue_t         iss,
  input  logic [pnz_pkg::COORD_W-1:0] cx,
  input  logic [pnz_pkg::COORD_W-1:0] cy,
  input  logic [pnz_pkg::COORD_W-1:0] cz,
  output pnz_pkg::pnz_issue_t         ctl_o,
  output logic signed [FRAC_BITS+2:0] val_o
);

  localparam int F   = FRAC_BITS;
  localparam int GW  = F + 3;
  localparam int XW  = F + 8;
  localparam int PW  = GW + F + 3;
  localparam int AW  = pnz_pkg::PERM_AW;
  localparam int ONE_M1 = (1 << F) - 1;
  localparam logic signed [GW-1:0] ONE_G = GW'(1) << F;

  function automatic logic signed [GW-1:0] grad(input logic [3:0] h,
                                                 input logic signed [F:0] x,
                                                 input logic signed [F:0] y,
                                                 input logic signed [F:0] z);
    logic signed [F:0] gu;
    logic signed [F:0] gv;
    gu = (h < pnz_pkg::GRAD_U_FROM_Y) ? x : y;
    if (h < pnz_pkg::GRAD_V_FROM_Y) begin
      gv = y;
    end else if (h == pnz_pkg::GRAD_V_X_A || h == pnz_pkg::GRAD_V_X_B) begin
      gv = x;
    end else begin
      gv = z;
    end
    return (h[0] ? -GW'(gu) : GW'(gu)) + (h[1] ? -GW'(gv) : GW'(gv));
  endfunction

  // a + w*(b-a) with the product truncated toward zero
  function automatic logic signed [GW-1:0] lerp(input logic signed [GW-1:0] a,
                                                 input logic signed [GW-1:0] b,
                                                 input logic [F:0] w);
    logic signed [GW:0]   d;
    logic signed [F+1:0]  ws;
    logic signed [PW-1:0] p;
    logic signed [PW-1:0] pa;
    d  = (GW + 1)'(b) - (GW + 1)'(a);
    ws = $signed({1'b0, w});
    p  = PW'(d) * PW'(ws);
    pa = p[PW-1] ? p + PW'(ONE_M1) : p;
    return a + GW'(pa >>> F);
  endfunction

  // scaled coordinates
  logic [XW-1:0] xs, ys, zs;
  assign xs = XW'(cx) << iss.octave;
  assign ys = XW'(cy) << iss.octave;
  assign zs = XW'(cz) << iss.octave;

  // stage 1: lattice cell and fraction
  pnz_pkg::pnz_issue_t s1_ctl_r;
  logic [AW-1:0] s1_xi_r, s1_yi_r, s1_zi_r;
  logic [F-1:0]  s1_xf_r, s1_yf_r, s1_zf_r;

  // stage 2: first hash level
  pnz_pkg::pnz_issue_t s2_ctl_r;
  logic [AW-1:0] s2_yi_r, s2_zi_r;
  logic [F-1:0]  s2_xf_r, s2_yf_r, s2_zf_r;
  logic [AW-1:0] pa0, pa1;
  logic [AW-1:0] ha, hb;

  // stage 3: second hash level
  pnz_pkg::pnz_issue_t s3_ctl_r;
  logic [AW-1:0] s3_zi_r;
  logic [F-1:0]  s3_xf_r, s3_yf_r, s3_zf_r;
  logic [AW-1:0] pb [4];
  logic [AW-1:0] haa, hab, hba, hbb;

  // stage 4: corner hashes and fades
  pnz_pkg::pnz_issue_t s4_ctl_r;
  logic [F-1:0]  s4_xf_r, s4_yf_r, s4_zf_r;
  logic [AW-1:0] hc [8];
  logic [F:0]    fu, fv, fw;
  logic signed [F:0] x0, x1, y0, y1, z0, z1;
  logic signed [GW-1:0] g [8];

  // stage 5: gradients, stages 6..8: interpolation
  pnz_pkg::pnz_issue_t s5_ctl_r, s6_ctl_r, s7_ctl_r, s8_ctl_r;
  logic signed [GW-1:0] s5_g_r [8];
  logic [F:0] s5_u_r, s5_v_r, s5_w_r, s6_v_r, s6_w_r, s7_w_r;
  logic signed [GW-1:0] s6_l_r [4];
  logic signed [GW-1:0] s7_m_r [2];
  logic signed [GW-1:0] s8_val_r;

  // valid and octave tags travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
      s2_ctl_r <= '0;
      s3_ctl_r <= '0;
      s4_ctl_r <= '0;
      s5_ctl_r <= '0;
      s6_ctl_r <= '0;
      s7_ctl_r <= '0;
      s8_ctl_r <= '0;
    end else begin
      s1_ctl_r <= iss;
      s2_ctl_r <= s1_ctl_r;
      s3_ctl_r <= s2_ctl_r;
      s4_ctl_r <= s3_ctl_r;
      s5_ctl_r <= s4_ctl_r;
      s6_ctl_r <= s5_ctl_r;
      s7_ctl_r <= s6_ctl_r;
      s8_ctl_r <= s7_ctl_r;
    end
  end

  // first permutation level
  pnz_perm_mem u_mem_a (
    .clk(clk), .wr(wr), .ra0(s1_xi_r), .ra1(s1_xi_r + 8'd1), .rd0(pa0), .rd1(pa1)
  );

  assign ha = pa0 + s2_yi_r;
  assign hb = pa1 + s2_yi_r;

  // second permutation level
  pnz_perm_mem u_mem_b0 (
    .clk(clk), .wr(wr), .ra0(ha), .ra1(ha + 8'd1), .rd0(pb[0]), .rd1(pb[1])
  );
  pnz_perm_mem u_mem_b1 (
    .clk(clk), .wr(wr), .ra0(hb), .ra1(hb + 8'd1), .rd0(pb[2]), .rd1(pb[3])
  );

  assign haa = pb[0] + s3_zi_r;
  assign hab = pb[1] + s3_zi_r;
  assign hba = pb[2] + s3_zi_r;
  assign hbb = pb[3] + s3_zi_r;

  // corner hashes: order aa, ba, ab, bb, then the same at z+1
  pnz_perm_mem u_mem_c0 (
    .clk(clk), .wr(wr), .ra0(haa), .ra1(haa + 8'd1), .rd0(hc[0]), .rd1(hc[4])
  );
  pnz_perm_mem u_mem_c1 (
    .clk(clk), .wr(wr), .ra0(hba), .ra1(hba + 8'd1), .rd0(hc[1]), .rd1(hc[5])
  );
  pnz_perm_mem u_mem_c2 (
    .clk(clk), .wr(wr), .ra0(hab), .ra1(hab + 8'd1), .rd0(hc[2]), .rd1(hc[6])
  );
  pnz_perm_mem u_mem_c3 (
    .clk(clk), .wr(wr), .ra0(hbb), .ra1(hbb + 8'd1), .rd0(hc[3]), .rd1(hc[7])
  );

  // fade curves, three stages from stage 1
  pnz_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .t(s1_xf_r), .f(fu));
  pnz_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .t(s1_yf_r), .f(fv));
  pnz_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .t(s1_zf_r), .f(fw));

  // corner offsets, the far side is fraction minus one
  assign x0 = $signed({1'b0, s4_xf_r});
  assign x1 = $signed({1'b1, s4_xf_r});
  assign y0 = $signed({1'b0, s4_yf_r});
  assign y1 = $signed({1'b1, s4_yf_r});
  assign z0 = $signed({1'b0, s4_zf_r});
  assign z1 = $signed({1'b1, s4_zf_r});

  assign g[0] = grad(hc[0][3:0], x0, y0, z0);
  assign g[1] = grad(hc[1][3:0], x1, y0, z0);
  assign g[2] = grad(hc[2][3:0], x0, y1, z0);
  assign g[3] = grad(hc[3][3:0], x1, y1, z0);
  assign g[4] = grad(hc[4][3:0], x0, y0, z1);
  assign g[5] = grad(hc[5][3:0], x1, y0, z1);
  assign g[6] = grad(hc[6][3:0], x0, y1, z1);
  assign g[7] = grad(hc[7][3:0], x1, y1, z1);

  // datapath registers
  always_ff @(posedge clk) begin
    s1_xi_r <= xs[F+7:F];
    s1_yi_r <= ys[F+7:F];
    s1_zi_r <= zs[F+7:F];
    s1_xf_r <= xs[F-1:0];
    s1_yf_r <= ys[F-1:0];
    s1_zf_r <= zs[F-1:0];

    s2_yi_r <= s1_yi_r;
    s2_zi_r <= s1_zi_r;
    s2_xf_r <= s1_xf_r;
    s2_yf_r <= s1_yf_r;
    s2_zf_r <= s1_zf_r;

    s3_zi_r <= s2_zi_r;
    s3_xf_r <= s2_xf_r;
    s3_yf_r <= s2_yf_r;
    s3_zf_r <= s2_zf_r;

    s4_xf_r <= s3_xf_r;
    s4_yf_r <= s3_yf_r;
    s4_zf_r <= s3_zf_r;

    for (int k = 0; k < 8; k++) begin
      s5_g_r[k] <= g[k];
    end
    s5_u_r <= fu;
    s5_v_r <= fv;
    s5_w_r <= fw;

    // along x
    s6_l_r[0] <= lerp(s5_g_r[0], s5_g_r[1], s5_u_r);
    s6_l_r[1] <= lerp(s5_g_r[2], s5_g_r[3], s5_u_r);
    s6_l_r[2] <= lerp(s5_g_r[4], s5_g_r[5], s5_u_r);
    s6_l_r[3] <= lerp(s5_g_r[6], s5_g_r[7], s5_u_r);
    s6_v_r    <= s5_v_r;
    s6_w_r    <= s5_w_r;

    // along y
    s7_m_r[0] <= lerp(s6_l_r[0], s6_l_r[1], s6_v_r);
    s7_m_r[1] <= lerp(s6_l_r[2], s6_l_r[3], s6_v_r);
    s7_w_r    <= s6_w_r;

    // along z, shifted up by one
    s8_val_r <= lerp(s7_m_r[0], s7_m_r[1], s7_w_r) + ONE_G;
  end

  assign ctl_o = s8_ctl_r;
  assign val_o = s8_val_r;

endmodule

`default_nettype wire

// ===== hw/rtl/pnz_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pnz_divider #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 38
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          req_valid,
  input  logic signed [NUM_W-1:0]       num,
  input  logic [DEN_W-1:0]              den,
  input  logic                          res_ready,
  output pnz_pkg::pnz_div_stat_t        stat,
  output logic [pnz_pkg::OUT_W-1:0]     quot
);

  localparam int RW = ((NUM_W > DEN_W) ? NUM_W : DEN_W) + 1;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state_r, state_nxt;
  logic [pnz_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [RW-1:0]               rem_r, rem_nxt;
  logic [RW-1:0]               den_r, den_nxt;
  logic [pnz_pkg::OUT_W-1:0]   q_r, q_nxt;
  logic [RW-1:0]               num_u;
  logic [RW-1:0]               rem2;

  assign num_u = RW'(num[NUM_W-2:0]);
  assign rem2  = {rem_r[RW-2:0], 1'b0};

  // restoring division, one quotient bit per cycle
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    q_nxt     = q_r;
    case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          den_nxt  = RW'(den);
          rem_nxt  = num_u;
          step_nxt = '0;
          q_nxt    = '0;
          if (num[NUM_W-1] || num == '0) begin
            state_nxt = ST_DONE;
          end else if (num_u >= RW'(den)) begin
            q_nxt     = pnz_pkg::OUT_MAX;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (rem2 >= den_r) begin
          rem_nxt = rem2 - den_r;
          q_nxt   = {q_r[pnz_pkg::OUT_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2;
          q_nxt   = {q_r[pnz_pkg::OUT_W-2:0], 1'b0};
        end
        step_nxt = step_r + 1'b1;
        if (step_r == '1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    q_r    <= q_nxt;
  end

  assign stat.req_ready = (state_r == ST_IDLE);
  assign stat.res_valid = (state_r == ST_DONE);
  assign quot           = q_r;

endmodule

`default_nettype wire
